// ===== rtl/core/nrt_pkg.sv =====
// ----------------------------------------------------------------------------
// nrt_pkg
// shared types, codes and checksum helpers of the nat redirect table
// ----------------------------------------------------------------------------
package nrt_pkg;

  localparam logic [1:0] OP_FWD = 2'd0;
  localparam logic [1:0] OP_REV = 2'd1;
  localparam logic [1:0] OP_QRY = 2'd2;

  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [7:0] PROTO_TCP    = 8'd6;

  localparam logic REG_LOCAL_IP   = 1'b0;
  localparam logic REG_PROXY_PORT = 1'b1;

  localparam int unsigned HASH_W  = 32;

  typedef enum logic [3:0] {
    ST_REDIRECTED  = 4'd0,
    ST_RESTORED    = 4'd1,
    ST_PASSED      = 4'd2,
    ST_REV_MISS    = 4'd3,
    ST_NOT_SYN     = 4'd4,
    ST_FULL        = 4'd5,
    ST_OVERWRITTEN = 4'd6,
    ST_QUERY_HIT   = 4'd7,
    ST_QUERY_MISS  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    K_PASS = 2'd0,
    K_FWD  = 2'd1,
    K_REV  = 2'd2,
    K_QRY  = 2'd3
  } kind_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] cli_addr;
    logic [15:0] cli_port;
    logic [31:0] orig_addr;
    logic [15:0] orig_port;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic        syn;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [15:0] ip_sum;
    logic [15:0] tcp_sum;
    logic [31:0] local_ip;
    logic [15:0] proxy_port;
    logic [15:0] fwd_ip_sum;
    logic [15:0] fwd_tcp_sum;
  } item_t;

  // ones-complement contribution of one word change
  function automatic logic [19:0] csum_word(input logic [15:0] oldw, input logic [15:0] neww);
    return {4'b0, ~oldw} + {4'b0, neww};
  endfunction

  function automatic logic [15:0] csum_finish(input logic [19:0] acc);
    logic [16:0] a;
    a = {1'b0, acc[15:0]} + {13'b0, acc[19:16]};
    a = a + {16'b0, a[16]};
    return ~a[15:0];
  endfunction

endpackage

// ===== rtl/core/nrt_fifo.sv =====
// ----------------------------------------------------------------------------
// nrt_fifo
// two-entry queue between the classifier front and the table back end
// ----------------------------------------------------------------------------
module nrt_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/nrt_front.sv =====
// ----------------------------------------------------------------------------
// nrt_front
// accepts requests, classifies them, hashes the key to a set and
// precomputes the forward rewrite checksums
// ----------------------------------------------------------------------------
module nrt_front import nrt_pkg::*; #(
  parameter int unsigned NSETS = 1024,
  parameter int unsigned SW    = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [3:0]        ip_version_i,
  input  logic [7:0]        protocol_i,
  input  logic [31:0]       src_addr_i,
  input  logic [15:0]       src_port_i,
  input  logic [31:0]       dst_addr_i,
  input  logic [15:0]       dst_port_i,
  input  logic              syn_flag_i,
  input  logic [15:0]       ip_sum_in_i,
  input  logic [15:0]       tcp_sum_in_i,
  input  logic [31:0]       local_ip_i,
  input  logic [15:0]       proxy_port_i,
  output logic              push_o,
  output item_t             item_o,
  output logic [SW-1:0]     set_o,
  input  logic              full_i
);

  localparam bit          IS_POW2 = ((NSETS & (NSETS - 1)) == 0);
  localparam logic [31:0] NSETS_W = 32'(NSETS);
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / NSETS);

  logic              busy_q, busy_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [HASH_W-1:0] h_q, h_d;
  logic [31:0]       q_q, q_d;
  logic [SW-1:0]     rem_q, rem_d;
  logic [1:0]        op_q;
  logic [3:0]        ver_q;
  logic [7:0]        proto_q;
  logic [31:0]       sa_q, da_q;
  logic [15:0]       sp_q, dp_q, ips_q, tcps_q;
  logic              syn_q;

  logic              accept;
  logic [HASH_W-1:0] key_sum;
  logic [63:0]       prod;
  logic [31:0]       r_est;
  logic [19:0]       ip_acc, tcp_acc;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = busy_q && (cnt_q == 2'd0) && !full_i;
  assign set_o      = rem_q;

  always_comb begin
    if (op_i == OP_REV) begin
      key_sum = dst_addr_i + {16'b0, dst_port_i};
    end else begin
      key_sum = src_addr_i + {16'b0, src_port_i};
    end
    // quotient estimate is at most one low, so one correction step
    prod  = {32'b0, h_q} * {32'b0, RECIP};
    r_est = h_q - q_q * NSETS_W;
    if (r_est >= NSETS_W) begin
      r_est = r_est - NSETS_W;
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    h_d    = h_q;
    q_d    = q_q;
    rem_d  = rem_q;
    if (accept) begin
      busy_d = 1'b1;
      if (IS_POW2) begin
        rem_d = key_sum[SW-1:0];
        cnt_d = 2'd0;
      end else begin
        h_d   = key_sum;
        cnt_d = 2'd2;
      end
    end else if (busy_q && cnt_q == 2'd2) begin
      q_d   = prod[63:32];
      cnt_d = 2'd1;
    end else if (busy_q && cnt_q == 2'd1) begin
      rem_d = r_est[SW-1:0];
      cnt_d = 2'd0;
    end else if (push_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    if (accept) begin
      op_q    <= op_i;
      ver_q   <= ip_version_i;
      proto_q <= protocol_i;
      sa_q    <= src_addr_i;
      sp_q    <= src_port_i;
      da_q    <= dst_addr_i;
      dp_q    <= dst_port_i;
      syn_q   <= syn_flag_i;
      ips_q   <= ip_sum_in_i;
      tcps_q  <= tcp_sum_in_i;
    end
  end

  always_comb begin
    ip_acc  = {4'b0, ~ips_q} + csum_word(da_q[31:16], local_ip_i[31:16])
            + csum_word(da_q[15:0], local_ip_i[15:0]);
    tcp_acc = {4'b0, ~tcps_q} + csum_word(da_q[31:16], local_ip_i[31:16])
            + csum_word(da_q[15:0], local_ip_i[15:0]) + csum_word(dp_q, proxy_port_i);

    item_o.kind = K_PASS;
    if (op_q == OP_QRY) begin
      item_o.kind = K_QRY;
    end else if (ver_q == IPV4_VERSION && proto_q == PROTO_TCP) begin
      if (op_q == OP_FWD) begin
        item_o.kind = K_FWD;
      end else if (op_q == OP_REV) begin
        item_o.kind = K_REV;
      end
    end
    item_o.syn         = syn_q;
    item_o.src_addr    = sa_q;
    item_o.src_port    = sp_q;
    item_o.dst_addr    = da_q;
    item_o.dst_port    = dp_q;
    item_o.ip_sum      = ips_q;
    item_o.tcp_sum     = tcps_q;
    item_o.local_ip    = local_ip_i;
    item_o.proxy_port  = proxy_port_i;
    item_o.fwd_ip_sum  = csum_finish(ip_acc);
    item_o.fwd_tcp_sum = csum_finish(tcp_acc);
  end

endmodule

// ===== rtl/core/nrt_back.sv =====
// ----------------------------------------------------------------------------
// nrt_back
// connection table memory: clearing pass, set read, resolve and write back,
// result register
// ----------------------------------------------------------------------------
module nrt_back import nrt_pkg::*; #(
  parameter int unsigned NSETS = 1024,
  parameter int unsigned SW    = 10,
  parameter int unsigned WAYS  = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  item_t         item_i,
  input  logic [SW-1:0] set_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [3:0]    status_o,
  output logic [31:0]   out_src_addr_o,
  output logic [15:0]   out_src_port_o,
  output logic [31:0]   out_dst_addr_o,
  output logic [15:0]   out_dst_port_o,
  output logic [15:0]   ip_sum_out_o,
  output logic [15:0]   tcp_sum_out_o
);

  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_e;

  state_e state_q, state_d;

  entry_t [WAYS-1:0] mem_q [NSETS];
  entry_t [WAYS-1:0] rd_row_q, wr_row;
  logic [SW-1:0]     wr_addr;
  logic              wr_en;

  logic          clr_busy_q;
  logic [SW-1:0] clr_idx_q;

  item_t         cur_q;
  logic [SW-1:0] set_q;

  logic          out_valid_q;
  status_e       status_q, status_d;
  logic [31:0]   osa_q, osa_d, oda_q, oda_d;
  logic [15:0]   osp_q, osp_d, odp_q, odp_d, oips_q, oips_d, otcps_q, otcps_d;

  logic          hit_any, free_any, tbl_wr;
  logic [WW-1:0] hit_way, free_way;
  entry_t        hit_e;
  entry_t [WAYS-1:0] new_row;
  logic [31:0]   key_addr;
  logic [15:0]   key_port;
  logic [19:0]   rev_ip_acc, rev_tcp_acc;

  assign pop_o = (state_q == S_IDLE) && !clr_busy_q && !empty_i
               && (!out_valid_q || out_ready_i);

  always_comb begin
    if (cur_q.kind == K_REV) begin
      key_addr = cur_q.dst_addr;
      key_port = cur_q.dst_port;
    end else begin
      key_addr = cur_q.src_addr;
      key_port = cur_q.src_port;
    end
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && rd_row_q[w].valid && rd_row_q[w].cli_addr == key_addr
          && rd_row_q[w].cli_port == key_port) begin
        hit_any = 1'b1;
        hit_way = WW'(w);
      end
      if (!free_any && !rd_row_q[w].valid) begin
        free_any = 1'b1;
        free_way = WW'(w);
      end
    end
    hit_e = rd_row_q[hit_way];
  end

  always_comb begin
    rev_ip_acc  = {4'b0, ~cur_q.ip_sum}
                + csum_word(cur_q.src_addr[31:16], hit_e.orig_addr[31:16])
                + csum_word(cur_q.src_addr[15:0], hit_e.orig_addr[15:0]);
    rev_tcp_acc = {4'b0, ~cur_q.tcp_sum}
                + csum_word(cur_q.src_addr[31:16], hit_e.orig_addr[31:16])
                + csum_word(cur_q.src_addr[15:0], hit_e.orig_addr[15:0])
                + csum_word(cur_q.src_port, hit_e.orig_port);

    new_row  = rd_row_q;
    tbl_wr   = 1'b0;
    status_d = ST_PASSED;
    osa_d    = cur_q.src_addr;
    osp_d    = cur_q.src_port;
    oda_d    = cur_q.dst_addr;
    odp_d    = cur_q.dst_port;
    oips_d   = cur_q.ip_sum;
    otcps_d  = cur_q.tcp_sum;
    unique case (cur_q.kind)
      K_QRY: begin
        oips_d  = '0;
        otcps_d = '0;
        if (hit_any) begin
          status_d = ST_QUERY_HIT;
          oda_d    = hit_e.orig_addr;
          odp_d    = hit_e.orig_port;
        end else begin
          status_d = ST_QUERY_MISS;
          oda_d    = '0;
          odp_d    = '0;
        end
      end
      K_REV: begin
        if (hit_any) begin
          status_d = ST_RESTORED;
          osa_d    = hit_e.orig_addr;
          osp_d    = hit_e.orig_port;
          oips_d   = csum_finish(rev_ip_acc);
          otcps_d  = csum_finish(rev_tcp_acc);
        end else begin
          status_d = ST_REV_MISS;
        end
      end
      K_FWD: begin
        if (hit_any && hit_e.orig_addr != cur_q.dst_addr
            && hit_e.orig_port != cur_q.dst_port) begin
          // both differ: stored destination replaced, no rewrite
          status_d                   = ST_OVERWRITTEN;
          tbl_wr                     = 1'b1;
          new_row[hit_way].orig_addr = cur_q.dst_addr;
          new_row[hit_way].orig_port = cur_q.dst_port;
        end else if (!hit_any && !cur_q.syn) begin
          status_d = ST_NOT_SYN;
        end else if (!hit_any && !free_any) begin
          status_d = ST_FULL;
        end else begin
          if (!hit_any) begin
            tbl_wr                      = 1'b1;
            new_row[free_way].valid     = 1'b1;
            new_row[free_way].cli_addr  = cur_q.src_addr;
            new_row[free_way].cli_port  = cur_q.src_port;
            new_row[free_way].orig_addr = cur_q.dst_addr;
            new_row[free_way].orig_port = cur_q.dst_port;
          end
          status_d = ST_REDIRECTED;
          oda_d    = cur_q.local_ip;
          odp_d    = cur_q.proxy_port;
          oips_d   = cur_q.fwd_ip_sum;
          otcps_d  = cur_q.fwd_tcp_sum;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_q;
      wr_row  = '0;
    end else begin
      wr_en   = (state_q == S_LOOK) && tbl_wr;
      wr_addr = set_q;
      wr_row  = new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (pop_o) begin
      rd_row_q <= mem_q[set_i];
      cur_q    <= item_i;
      set_q    <= set_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + SW'(1);
        if (clr_idx_q == SW'(NSETS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (state_q == S_LOOK) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) begin
      status_q <= status_d;
      osa_q    <= osa_d;
      osp_q    <= osp_d;
      oda_q    <= oda_d;
      odp_q    <= odp_d;
      oips_q   <= oips_d;
      otcps_q  <= otcps_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_src_addr_o = osa_q;
  assign out_src_port_o = osp_q;
  assign out_dst_addr_o = oda_q;
  assign out_dst_port_o = odp_q;
  assign ip_sum_out_o   = oips_q;
  assign tcp_sum_out_o  = otcps_q;

  a_look_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |-> !out_valid_q)
    else $error("result slot busy during lookup");

  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pop_o && state_q == S_IDLE)
    else $error("table used during clearing pass");

  a_result_from_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_LOOK))
    else $error("result without lookup");

endmodule

// ===== rtl/core/tcp_nat_redirect_table.sv =====
// ----------------------------------------------------------------------------
// tcp_nat_redirect_table
// destination nat connection table with incremental checksum update
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    op .. tcp_sum_in
//   out      source     out_valid/out_ready  status .. tcp_sum_out
//   apb      slave      psel/penable/pready  local_ip, proxy_port
//
// front takes the set index from the low key bits when the set count is a
// power of two, else by reciprocal multiply and one correction; back reads
// the set, then resolves and writes back
// after reset the table clears one set per cycle, TABLE_ENTRIES/TABLE_WAYS
// sets in all, before the back end takes up the first request
// the queue lets the front keep accepting until full while the result waits
// ----------------------------------------------------------------------------
module tcp_nat_redirect_table import nrt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned TABLE_WAYS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  ip_version_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] dst_port_i,
  input  logic        syn_flag_i,
  input  logic [15:0] ip_sum_in_i,
  input  logic [15:0] tcp_sum_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [31:0] out_src_addr_o,
  output logic [15:0] out_src_port_o,
  output logic [31:0] out_dst_addr_o,
  output logic [15:0] out_dst_port_o,
  output logic [15:0] ip_sum_out_o,
  output logic [15:0] tcp_sum_out_o
);

  localparam int unsigned NSETS  = (TABLE_ENTRIES / TABLE_WAYS > 0) ?
                                   TABLE_ENTRIES / TABLE_WAYS : 1;
  localparam int unsigned SW     = (NSETS > 1) ? $clog2(NSETS) : 1;
  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned Q_W    = ITEM_W + SW;

  logic [31:0] local_ip_q;
  logic [15:0] proxy_port_q;
  logic        cfg_wr;

  logic          push, pop, full, empty;
  item_t         f_item, b_item;
  logic [SW-1:0] f_set, b_set;
  logic [Q_W-1:0] q_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q   <= '0;
      proxy_port_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LOCAL_IP) begin
        local_ip_q <= pwdata;
      end else begin
        proxy_port_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_PROXY_PORT) begin
      prdata = {16'b0, proxy_port_q};
    end else begin
      prdata = local_ip_q;
    end
  end

  nrt_front #(.NSETS(NSETS), .SW(SW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .ip_version_i, .protocol_i,
    .src_addr_i, .src_port_i, .dst_addr_i, .dst_port_i, .syn_flag_i,
    .ip_sum_in_i, .tcp_sum_in_i,
    .local_ip_i   (local_ip_q),
    .proxy_port_i (proxy_port_q),
    .push_o       (push),
    .item_o       (f_item),
    .set_o        (f_set),
    .full_i       (full)
  );

  nrt_fifo #(.W(Q_W)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  ({f_set, f_item}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (empty)
  );

  assign b_item = item_t'(q_out[ITEM_W-1:0]);
  assign b_set  = q_out[Q_W-1:ITEM_W];

  nrt_back #(.NSETS(NSETS), .SW(SW), .WAYS(TABLE_WAYS)) u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .item_i  (b_item),
    .set_i   (b_set),
    .pop_o   (pop),
    .out_valid_o, .out_ready_i, .status_o, .out_src_addr_o, .out_src_port_o,
    .out_dst_addr_o, .out_dst_port_o, .ip_sum_out_o, .tcp_sum_out_o
  );

endmodule
